[src/assert_macros.svh]
// -----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ccg_pkg.sv]
// -----------------------------------------------------------------------------
// ccg_pkg
// Widths, codes and shared types of the credit chunk granter.
// -----------------------------------------------------------------------------
package ccg_pkg;

  localparam int MAX_CLIENTS = 16;
  localparam int SLOT_W      = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int ID_W        = 16;
  localparam int CREDIT_W    = 21;
  localparam int TOTAL_W     = CREDIT_W + 1;
  localparam int SEQ_W       = 32;
  localparam int GRANT_CAP   = 33;
  localparam int CNT_W       = $clog2(GRANT_CAP + 1);

  localparam logic [CREDIT_W-1:0] CHUNK_RESET = CREDIT_W'(65536);
  localparam logic [CREDIT_W-1:0] CREDIT_MAX  = '1;

  localparam logic STATUS_GRANT = 1'b0;
  localparam logic STATUS_FULL  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_READ,
    ST_GRANT,
    ST_ERROR,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic              hit;
    logic              avail;
    logic [SLOT_W-1:0] slot;
  } lookup_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
  } claim_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [CREDIT_W-1:0] credit;
  } slot_entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    slot_entry_t       wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

endpackage

[src/ccg_credit_if.sv]
// -----------------------------------------------------------------------------
// ccg_credit_if
// Credit message channel: client id and byte credit.
// -----------------------------------------------------------------------------
interface ccg_credit_if;
  import ccg_pkg::*;

  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     client_id;
  logic [CREDIT_W-1:0] credit_bytes;

  modport source (output valid, client_id, credit_bytes, input ready);
  modport sink   (input valid, client_id, credit_bytes, output ready);
endinterface

[src/ccg_grant_if.sv]
// -----------------------------------------------------------------------------
// ccg_grant_if
// Result channel: chunk grants and table-full errors.
// -----------------------------------------------------------------------------
interface ccg_grant_if;
  import ccg_pkg::*;

  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  dest_client;
  logic [SEQ_W-1:0] chunk_seq;
  logic             status;
  logic             last;

  modport source (output valid, dest_client, chunk_seq, status, last, input ready);
  modport sink   (input valid, dest_client, chunk_seq, status, last, output ready);
endinterface

[src/ccg_cfg_if.sv]
// -----------------------------------------------------------------------------
// ccg_cfg_if
// Configuration write channel for the chunk size register.
// -----------------------------------------------------------------------------
interface ccg_cfg_if;
  import ccg_pkg::*;

  logic                valid;
  logic                ready;
  logic [CREDIT_W-1:0] chunk_bytes;

  modport source (output valid, chunk_bytes, input ready);
  modport sink   (input valid, chunk_bytes, output ready);
endinterface

[src/ccg_slot_ram.sv]
// -----------------------------------------------------------------------------
// ccg_slot_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// -----------------------------------------------------------------------------
module ccg_slot_ram #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 53,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ccg_tag_cam.sv]
// -----------------------------------------------------------------------------
// ccg_tag_cam
// Slot valid bits and client tags; parallel id match and lowest free slot.
// -----------------------------------------------------------------------------
module ccg_tag_cam (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [ccg_pkg::ID_W-1:0] lookup_id,
  input  ccg_pkg::claim_t        claim,
  output ccg_pkg::lookup_t       lookup
);
  import ccg_pkg::*;

  logic [MAX_CLIENTS-1:0] slot_valid;
  logic [ID_W-1:0]        slot_client [MAX_CLIENTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (claim.en) begin
      slot_valid[claim.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (claim.en) begin
      slot_client[claim.slot] <= claim.id;
    end
  end

  // Tags of valid slots are distinct, so at most one entry matches.
  always_comb begin
    lookup = '0;
    for (int i = MAX_CLIENTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        lookup.avail = 1'b1;
        if (!lookup.hit) begin
          lookup.slot = SLOT_W'(i);
        end
      end
    end
    for (int i = 0; i < MAX_CLIENTS; i++) begin
      if (slot_valid[i] && slot_client[i] == lookup_id) begin
        lookup.hit  = 1'b1;
        lookup.slot = SLOT_W'(i);
      end
    end
  end

endmodule

[src/ccg_grant_fsm.sv]
// -----------------------------------------------------------------------------
// ccg_grant_fsm
// Sequencer: lookup, slot read on a hit, one grant per cycle unless stalled, write back or full error; result register.
// -----------------------------------------------------------------------------
module ccg_grant_fsm (
  input  logic                         clk,
  input  logic                         rst,
  ccg_credit_if.sink                   credit_in,
  ccg_grant_if.source                  grant_out,
  input  logic [ccg_pkg::CREDIT_W-1:0] chunk_bytes,
  input  ccg_pkg::lookup_t             lookup,
  output logic [ccg_pkg::ID_W-1:0]     lookup_id,
  output ccg_pkg::claim_t              claim,
  output ccg_pkg::ram_req_t            ram_req,
  input  ccg_pkg::slot_entry_t         ram_rdata
);
  import ccg_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(GRANT_CAP);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(GRANT_CAP - 1);

  state_t              state, state_next;
  logic [ID_W-1:0]     client, client_next;
  logic [CREDIT_W-1:0] credit, credit_next;
  logic [SLOT_W-1:0]   slot, slot_next;
  logic [TOTAL_W-1:0]  total, total_next;
  logic [SEQ_W-1:0]    seq, seq_next;
  logic [CNT_W-1:0]    cnt, cnt_next;

  logic             out_valid, out_valid_next;
  logic [SEQ_W-1:0] out_seq, out_seq_next;
  logic             out_status, out_status_next;
  logic             out_last, out_last_next;
  logic             out_load;

  logic               out_free;
  logic [TOTAL_W-1:0] chunk_ext;
  logic [TOTAL_W-1:0] rem;
  logic               can_grant;

  assign out_free  = !out_valid || grant_out.ready;
  assign chunk_ext = {1'b0, chunk_bytes};
  assign rem       = total - chunk_ext;
  assign can_grant = (cnt != CAP_CNT) && (total >= chunk_ext);

  assign credit_in.ready       = (state == ST_IDLE);
  assign lookup_id             = client;
  assign grant_out.valid       = out_valid;
  assign grant_out.chunk_seq   = out_seq;
  assign grant_out.status      = out_status;
  assign grant_out.last        = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    client <= client_next;
    credit <= credit_next;
    slot   <= slot_next;
    total  <= total_next;
    seq    <= seq_next;
    cnt    <= cnt_next;
    if (out_load) begin
      grant_out.dest_client <= client;
      out_seq               <= out_seq_next;
      out_status            <= out_status_next;
      out_last              <= out_last_next;
    end
  end

  always_comb begin
    state_next      = state;
    client_next     = client;
    credit_next     = credit;
    slot_next       = slot;
    total_next      = total;
    seq_next        = seq;
    cnt_next        = cnt;
    out_load        = 1'b0;
    out_seq_next    = out_seq;
    out_status_next = out_status;
    out_last_next   = out_last;
    claim           = '0;
    ram_req         = '0;

    unique case (state)
      ST_IDLE: begin
        if (credit_in.valid) begin
          client_next = credit_in.client_id;
          credit_next = credit_in.credit_bytes;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        slot_next = lookup.slot;
        cnt_next  = '0;
        if (lookup.hit) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = lookup.slot;
          state_next    = ST_READ;
        end else if (lookup.avail) begin
          // New client: fresh slot starts at zero credit and sequence
          claim.en    = 1'b1;
          claim.slot  = lookup.slot;
          claim.id    = client;
          total_next  = {1'b0, credit};
          seq_next    = '0;
          state_next  = ST_GRANT;
        end else begin
          state_next = ST_ERROR;
        end
      end
      ST_READ: begin
        total_next = {1'b0, ram_rdata.credit} + {1'b0, credit};
        seq_next   = ram_rdata.seq;
        state_next = ST_GRANT;
      end
      ST_GRANT: begin
        if (!can_grant) begin
          state_next = ST_WRITE;
        end else if (out_free) begin
          out_load        = 1'b1;
          out_seq_next    = seq;
          out_status_next = STATUS_GRANT;
          out_last_next   = (cnt == LAST_CNT) || (rem < chunk_ext);
          total_next      = rem;
          seq_next        = seq + 1'b1;
          cnt_next        = cnt + 1'b1;
        end
      end
      ST_ERROR: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_seq_next    = '0;
          out_status_next = STATUS_FULL;
          out_last_next   = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_WRITE: begin
        ram_req.we           = 1'b1;
        ram_req.waddr        = slot;
        ram_req.wdata.seq    = seq;
        ram_req.wdata.credit = total[TOTAL_W-1] ? CREDIT_MAX : total[CREDIT_W-1:0];
        state_next           = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (grant_out.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

[src/per_client_credit_chunk_granter.sv]
// -----------------------------------------------------------------------------
// per_client_credit_chunk_granter: one credit message in, up to GRANT_CAP grants out,
// or one table-full result. Resident client: lookup, slot read, grants, write back;
// a new one claims a slot and skips the read. Results come from a result register.
// Rate: one grant per cycle unless stalled; next message after write back or error result.
// Reset clears slot valid bits at once and sets chunk size to 64 KiB.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module per_client_credit_chunk_granter (
  input  logic        clk,
  input  logic        rst,
  ccg_credit_if.sink  credit_in,
  ccg_grant_if.source grant_out,
  ccg_cfg_if.sink     cfg
);
  import ccg_pkg::*;

  logic [CREDIT_W-1:0] chunk_bytes;
  logic [ID_W-1:0]     lookup_id;
  lookup_t             lookup;
  claim_t              claim;
  ram_req_t            ram_req;
  slot_entry_t         ram_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes <= CHUNK_RESET;
    end else if (cfg.valid) begin
      chunk_bytes <= cfg.chunk_bytes;
    end
  end

  ccg_tag_cam u_tag_cam (
    .clk       (clk),
    .rst       (rst),
    .lookup_id (lookup_id),
    .claim     (claim),
    .lookup    (lookup)
  );

  ccg_slot_ram #(
    .DEPTH  (MAX_CLIENTS),
    .DATA_W ($bits(slot_entry_t))
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  ccg_grant_fsm u_grant_fsm (
    .clk         (clk),
    .rst         (rst),
    .credit_in   (credit_in),
    .grant_out   (grant_out),
    .chunk_bytes (chunk_bytes),
    .lookup      (lookup),
    .lookup_id   (lookup_id),
    .claim       (claim),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata)
  );

  `ASSERT_IMPLIES(a_full_is_single, clk, rst,
    grant_out.valid && grant_out.status == STATUS_FULL,
    grant_out.last && grant_out.chunk_seq == '0,
    "table-full result must be a lone last result with zero sequence")

  `ASSERT_NEXT(a_one_msg_at_a_time, clk, rst,
    credit_in.valid && credit_in.ready,
    !credit_in.ready,
    "credit accepted while previous message still in progress")

  `ASSERT_NEXT(a_run_same_client, clk, rst,
    grant_out.valid && grant_out.ready && !grant_out.last,
    grant_out.dest_client == $past(grant_out.dest_client),
    "grant run switched client before its last result")

  `ASSERT_IMPLIES(a_no_claim_on_hit, clk, rst,
    claim.en,
    !lookup.hit && lookup.avail,
    "slot claimed for a client already in the table or with no free slot")

endmodule
